// ===== rtl/ssr_pkg.sv =====
// ----------------------------------------------------------------------------
// Seven-segment serial refresh package
// Shared widths, codes, reciprocal tables, the event record and the segment
// pattern lookup.
// ----------------------------------------------------------------------------
package ssr_pkg;

    localparam int DIGIT_COUNT_DEF = 4;
    localparam int DIGIT_COUNT_MAX = 8;

    localparam int NUMBER_W    = 16;
    localparam int DIGIT_W     = 4;
    localparam int SEG_W       = 8;
    localparam int MAP_LOW_W   = 64;
    localparam int MAP_HIGH_W  = 16;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 64;
    localparam int EVENT_IDX_W = 5;
    localparam int POS_OUT_W   = 2;
    localparam int POS_WIDE_W  = 3;
    localparam int PROD_W      = 48;

    localparam logic [EVENT_IDX_W-1:0] LATCH_EVENT = 5'd16;
    localparam logic [EVENT_IDX_W-1:0] SHIFT_SEG_END = 5'd8;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    localparam logic EV_SHIFT = 1'b0;
    localparam logic EV_LATCH = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] CFG_SEGMENT_MAP_LOW  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEGMENT_MAP_HIGH = 1'b1;

    // Entry j-1 gives ceil(2^S / 10^j) and S = 16 + ceil(log2(10^j)). The
    // fractional part of n * M / 2^S times ten yields digit floor(n/10^(j-1)) mod 10
    // exactly for every 16-bit n.
    localparam logic [16:0] RECIP_MUL [DIGIT_COUNT_MAX] = '{
        17'd104858, 17'd83887, 17'd67109, 17'd107375,
        17'd85900,  17'd68720, 17'd109952, 17'd87961
    };
    localparam int RECIP_SHIFT [DIGIT_COUNT_MAX] = '{
        20, 23, 26, 30, 33, 36, 40, 43
    };

    typedef struct packed {
        logic                 kind;
        logic                 serial_bit;
        logic [POS_OUT_W-1:0] position;
        logic                 frame_end;
    } ssr_event_t;

    function automatic logic [SEG_W-1:0] pattern_of(
        input logic [DIGIT_W-1:0]    d,
        input logic [MAP_LOW_W-1:0]  map_low,
        input logic [MAP_HIGH_W-1:0] map_high
    );
        logic [SEG_W-1:0] p;
        if (d < 4'd8) begin
            p = map_low[{d[2:0], 3'b000} +: SEG_W];
        end else if (d == 4'd8) begin
            p = map_high[7:0];
        end else if (d == 4'd9) begin
            p = map_high[15:8];
        end else begin
            p = '0;
        end
        return p;
    endfunction

endpackage

// ===== rtl/ssr_digit_split.sv =====
// ----------------------------------------------------------------------------
// Decimal digit splitter
// Splits a 16-bit number into decimal digits, most significant first, with
// one constant reciprocal multiply per digit.
// ----------------------------------------------------------------------------
module ssr_digit_split #(
    parameter int DIGIT_COUNT = ssr_pkg::DIGIT_COUNT_DEF
) (
    input  logic [ssr_pkg::NUMBER_W-1:0]                   number,
    output logic [DIGIT_COUNT-1:0][ssr_pkg::DIGIT_W-1:0]   digits
);

    localparam int PW = ssr_pkg::PROD_W;

    for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_digit
        localparam int J = DIGIT_COUNT - i;
        localparam int S = ssr_pkg::RECIP_SHIFT[J-1];
        localparam logic [PW-1:0] MUL = PW'(ssr_pkg::RECIP_MUL[J-1]);
        localparam logic [PW-1:0] FRAC_MASK = (PW'(1) << S) - PW'(1);

        logic [PW-1:0] prod;
        logic [PW-1:0] frac;
        logic [PW+3:0] frac_x10;

        assign prod     = PW'(number) * MUL;
        assign frac     = prod & FRAC_MASK;
        assign frac_x10 = ({4'b0000, frac} << 3) + ({4'b0000, frac} << 1);
        assign digits[i] = ssr_pkg::DIGIT_W'(frac_x10 >> S);
    end

endmodule

// ===== rtl/ssr_refresh_core.sv =====
// ----------------------------------------------------------------------------
// Refresh sequencer
// Holds the digit store and the position and event counters, and forms the
// current pin event of the refresh frame.
// ----------------------------------------------------------------------------
module ssr_refresh_core #(
    parameter int DIGIT_COUNT = ssr_pkg::DIGIT_COUNT_DEF
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         load_en,
    input  logic [DIGIT_COUNT-1:0][ssr_pkg::DIGIT_W-1:0] load_digits,
    input  logic                                         tick_en,
    input  logic [ssr_pkg::MAP_LOW_W-1:0]                map_low,
    input  logic [ssr_pkg::MAP_HIGH_W-1:0]               map_high,
    output ssr_pkg::ssr_event_t                          event_out
);

    localparam int PW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam logic [PW-1:0] POS_LAST = PW'(DIGIT_COUNT - 1);

    logic [ssr_pkg::DIGIT_W-1:0]     digit_reg [DIGIT_COUNT];
    logic [PW-1:0]                   pos_reg;
    logic [PW-1:0]                   pos_next;
    logic [ssr_pkg::EVENT_IDX_W-1:0] ev_reg;
    logic [ssr_pkg::EVENT_IDX_W-1:0] ev_next;

    logic [ssr_pkg::SEG_W-1:0]       pattern;
    logic [ssr_pkg::SEG_W-1:0]       cathode;
    logic [2:0]                      bit_sel;
    logic [ssr_pkg::POS_WIDE_W-1:0]  pos_wide;
    logic                            is_latch;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                digit_reg[i] <= '0;
            end
        end else if (load_en) begin
            for (int i = 0; i < DIGIT_COUNT; i++) begin
                digit_reg[i] <= load_digits[i];
            end
        end
    end

    always_comb begin
        is_latch = (ev_reg >= ssr_pkg::LATCH_EVENT);
        pos_next = pos_reg;
        ev_next  = ev_reg;
        if (tick_en) begin
            if (is_latch) begin
                ev_next  = '0;
                pos_next = (pos_reg == POS_LAST) ? '0 : pos_reg + PW'(1);
            end else begin
                ev_next = ev_reg + ssr_pkg::EVENT_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
            ev_reg  <= '0;
        end else begin
            pos_reg <= pos_next;
            ev_reg  <= ev_next;
        end
    end

    always_comb begin
        pattern  = ssr_pkg::pattern_of(digit_reg[pos_reg], map_low, map_high);
        cathode  = ssr_pkg::SEG_W'(1) << pos_reg;
        bit_sel  = ~ev_reg[2:0];
        pos_wide = ssr_pkg::POS_WIDE_W'(pos_reg);

        event_out.position = pos_wide[ssr_pkg::POS_OUT_W-1:0];
        if (is_latch) begin
            event_out.kind       = ssr_pkg::EV_LATCH;
            event_out.serial_bit = 1'b0;
            event_out.frame_end  = (pos_reg == POS_LAST);
        end else begin
            event_out.kind       = ssr_pkg::EV_SHIFT;
            event_out.frame_end  = 1'b0;
            if (ev_reg < ssr_pkg::SHIFT_SEG_END) begin
                event_out.serial_bit = pattern[bit_sel];
            end else begin
                event_out.serial_bit = cathode[bit_sel];
            end
        end
    end

endmodule

// ===== rtl/seven_segment_serial_refresh_unit.sv =====
// ----------------------------------------------------------------------------
// Seven-segment serial refresh unit
// Drives a multi-digit seven-segment display through a serial shift register,
// one pin event per refresh tick.
// ----------------------------------------------------------------------------
// A load transfer (operation 0) splits number_value into DIGIT_COUNT decimal
// digits, most significant first, and produces no result. Each tick transfer
// (operation 1) produces one result: the next event of the endless refresh,
// which for every digit position sends 8 segment bits, 8 cathode bits and a
// latch pulse. The unit takes one transfer per cycle unless a tick is held in
// the input register by a result not yet taken. A tick passes the input
// register and the result register, with the event logic in between. Segment
// patterns are read from the two map registers when each bit is formed.
// ----------------------------------------------------------------------------
module seven_segment_serial_refresh_unit #(
    parameter int DIGIT_COUNT = ssr_pkg::DIGIT_COUNT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic [ssr_pkg::CFG_INDEX_W-1:0]   cfg_wr_index,
    input  logic [ssr_pkg::CFG_DATA_W-1:0]    cfg_wr_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_operation,
    input  logic [ssr_pkg::NUMBER_W-1:0]      s_number_value,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_event_kind,
    output logic                              m_serial_bit,
    output logic [ssr_pkg::POS_OUT_W-1:0]     m_digit_position,
    output logic                              m_frame_end
);

    logic [ssr_pkg::MAP_LOW_W-1:0]  map_low_reg;
    logic [ssr_pkg::MAP_HIGH_W-1:0] map_high_reg;

    logic                           in_valid_reg;
    logic                           in_op_reg;
    logic [ssr_pkg::NUMBER_W-1:0]   in_number_reg;

    logic                           m_valid_reg;
    logic                           m_valid_next;
    ssr_pkg::ssr_event_t            m_event_reg;

    logic                           out_ready;
    logic                           advance;
    logic                           load_en;
    logic                           tick_en;
    ssr_pkg::ssr_event_t            event_cur;
    logic [DIGIT_COUNT-1:0][ssr_pkg::DIGIT_W-1:0] split_digits;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_low_reg  <= '0;
            map_high_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                ssr_pkg::CFG_SEGMENT_MAP_LOW: begin
                    map_low_reg <= cfg_wr_data;
                end
                ssr_pkg::CFG_SEGMENT_MAP_HIGH: begin
                    map_high_reg <= cfg_wr_data[ssr_pkg::MAP_HIGH_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign out_ready = !m_valid_reg || m_ready;
    assign advance   = in_valid_reg && ((in_op_reg == ssr_pkg::OP_LOAD) || out_ready);
    assign load_en   = advance && (in_op_reg == ssr_pkg::OP_LOAD);
    assign tick_en   = advance && (in_op_reg == ssr_pkg::OP_TICK);
    assign s_ready   = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_op_reg     <= s_operation;
            in_number_reg <= s_number_value;
        end
    end

    ssr_digit_split #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_split (
        .number (in_number_reg),
        .digits (split_digits)
    );

    ssr_refresh_core #(
        .DIGIT_COUNT (DIGIT_COUNT)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .load_en     (load_en),
        .load_digits (split_digits),
        .tick_en     (tick_en),
        .map_low     (map_low_reg),
        .map_high    (map_high_reg),
        .event_out   (event_cur)
    );

    always_comb begin
        if (tick_en) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_en) begin
            m_event_reg <= event_cur;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_event_kind     = m_event_reg.kind;
    assign m_serial_bit     = m_event_reg.serial_bit;
    assign m_digit_position = m_event_reg.position;
    assign m_frame_end      = m_event_reg.frame_end;

endmodule
